/* rtl/spq_pkg.sv */
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W = 4;
    localparam int COUNT_W = 5;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE_MAX = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_VALUE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_DEL
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  key;
    } cell_ctrl_t;

endpackage

/* rtl/sorted_priority_queue_unit.sv */
// channel   direction  handshake                 fields
// request   in         start high, busy low      kind, value, new_value
// result    out        done, one cycle, no stall status, position, out_value, count
//
// done is raised by the shift edge (compare at the accepting edge, shift at the next);
// a change that finds its match raises done only after S_ACT, S_RECMP and S_ACT again, as the
// new value needs a second compare and shift pass; busy is high until the edge that raises
// done, so the next item can be taken at the edge that ends the done cycle
// reset clears the fill count and the sequencer; the entries hold no reset value
// the receiver cannot stall: each result is shown for exactly one cycle
module sorted_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [spq_pkg::KIND_W-1:0]          kind,
    input  logic signed [spq_pkg::DATA_W-1:0]   value,
    input  logic signed [spq_pkg::DATA_W-1:0]   new_value,
    output logic                                done,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic [spq_pkg::POS_W-1:0]           position,
    output logic signed [spq_pkg::DATA_W-1:0]   out_value,
    output logic [spq_pkg::COUNT_W-1:0]         count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // idle, act on compare flags, compare again with the new value of a change
    typedef enum logic [1:0] {
        S_IDLE,
        S_ACT,
        S_RECMP
    } state_t;

    state_t                             state_reg;
    logic [CNT_W-1:0]                   fill_reg;
    logic [spq_pkg::KIND_W-1:0]         kind_reg;
    logic signed [spq_pkg::DATA_W-1:0]  value_reg;
    logic signed [spq_pkg::DATA_W-1:0]  nval_reg;
    logic                               ins_phase_reg;
    logic [IDX_W-1:0]                   sav_pos_reg;
    logic                               done_reg;
    logic [spq_pkg::STATUS_W-1:0]       status_reg;
    logic [spq_pkg::POS_W-1:0]          position_reg;
    logic signed [spq_pkg::DATA_W-1:0]  out_value_reg;
    logic [spq_pkg::COUNT_W-1:0]        count_reg;

    spq_pkg::cell_ctrl_t                ctrl;

    // per-cell views of the row
    logic signed [spq_pkg::DATA_W-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]                   lt_v;
    logic [DEPTH-1:0]                   eq_v;
    logic [DEPTH-1:0]                   le_v;
    logic [DEPTH-1:0]                   occ_v;

    // decoded from the flags
    logic                               hit;
    logic                               full;
    logic [IDX_W-1:0]                   match_idx;
    logic [IDX_W-1:0]                   ins_idx;
    logic [IDX_W-1:0]                   top_idx;
    logic signed [spq_pkg::DATA_W-1:0]  top_value;
    logic [CNT_W-1:0]                   fill_dec;
    logic signed [spq_pkg::DATA_W-1:0]  ins_key;
    logic                               is_insert;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign fill_dec  = fill_reg - 1'b1;
    assign top_idx   = fill_dec[IDX_W-1:0];
    assign le_v      = lt_v | eq_v;
    assign hit       = |eq_v;
    assign ins_key   = ins_phase_reg ? nval_reg : value_reg;
    assign is_insert = ins_phase_reg || (kind_reg == spq_pkg::KIND_INSERT);

    // occupancy follows the fill count, entries sit at the low end
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ_v[i] = (fill_reg > CNT_W'(i));
        end
    end

    // one-hot picks over the row: first match, insertion point, top entry
    always_comb
    begin
        match_idx = '0;
        ins_idx   = '0;
        top_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (eq_v[i] && ((i == 0) || !eq_v[(i == 0) ? 0 : i - 1]))
            begin
                match_idx = match_idx | IDX_W'(i);
            end
            if (!le_v[i] && ((i == 0) || le_v[(i == 0) ? 0 : i - 1]))
            begin
                ins_idx = ins_idx | IDX_W'(i);
            end
            if (occ_v[i] && ((i == DEPTH - 1) || !occ_v[(i == DEPTH - 1) ? i : i + 1]))
            begin
                top_value = top_value | cell_data[i];
            end
        end
    end

    // cell row control, broadcast to every cell
    always_comb
    begin
        ctrl.op  = spq_pkg::CELL_HOLD;
        ctrl.key = value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op = spq_pkg::CELL_CMP;
                end
            end
            S_RECMP:
            begin
                ctrl.op  = spq_pkg::CELL_CMP;
                ctrl.key = nval_reg;
            end
            S_ACT:
            begin
                ctrl.key = ins_key;
                if (is_insert)
                begin
                    if (!full)
                    begin
                        ctrl.op = spq_pkg::CELL_INS;
                    end
                end
                else if ((kind_reg == spq_pkg::KIND_REMOVE_VALUE ||
                          kind_reg == spq_pkg::KIND_CHANGE) && hit)
                begin
                    ctrl.op = spq_pkg::CELL_DEL;
                end
            end
            default:
            begin
                ctrl.op = spq_pkg::CELL_HOLD;
            end
        endcase
    end

    // row of cells, each linked to its neighbours
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [spq_pkg::DATA_W-1:0] left_data;
            logic                              left_le;
            logic signed [spq_pkg::DATA_W-1:0] right_data;

            if (g == 0)
            begin : g_low
                assign left_data = ctrl.key;
                assign left_le   = 1'b1;
            end
            else
            begin : g_mid
                assign left_data = cell_data[g-1];
                assign left_le   = le_v[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_high
                assign right_data = cell_data[g];
            end
            else
            begin : g_inner
                assign right_data = cell_data[g+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .occ        (occ_v[g]),
                .left_data  (left_data),
                .left_le    (left_le),
                .right_data (right_data),
                .data       (cell_data[g]),
                .lt         (lt_v[g]),
                .eq         (eq_v[g])
            );
        end
    endgenerate

    // sequencer with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            kind_reg      <= '0;
            value_reg     <= '0;
            nval_reg      <= '0;
            ins_phase_reg <= 1'b0;
            sav_pos_reg   <= '0;
            done_reg      <= 1'b0;
            status_reg    <= spq_pkg::STATUS_OK;
            position_reg  <= '0;
            out_value_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg      <= kind;
                        value_reg     <= value;
                        nval_reg      <= new_value;
                        ins_phase_reg <= 1'b0;
                        state_reg     <= S_ACT;
                    end
                end
                S_RECMP:
                begin
                    state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    state_reg     <= S_IDLE;
                    done_reg      <= 1'b1;
                    status_reg    <= spq_pkg::STATUS_OK;
                    position_reg  <= '0;
                    out_value_reg <= '0;
                    count_reg     <= spq_pkg::COUNT_W'({{spq_pkg::COUNT_W{1'b0}}, fill_reg});
                    if (ins_phase_reg)
                    begin
                        // second half of a change: report the removed match
                        fill_reg      <= fill_reg + 1'b1;
                        count_reg     <= spq_pkg::COUNT_W'({{spq_pkg::COUNT_W{1'b0}},
                                                            fill_reg + 1'b1});
                        position_reg  <= spq_pkg::POS_W'({{spq_pkg::POS_W{1'b0}}, sav_pos_reg});
                        out_value_reg <= value_reg;
                    end
                    else
                    begin
                        unique case (kind_reg) inside
                            spq_pkg::KIND_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= spq_pkg::STATUS_FULL;
                                end
                                else
                                begin
                                    fill_reg     <= fill_reg + 1'b1;
                                    count_reg    <= spq_pkg::COUNT_W'(
                                        {{spq_pkg::COUNT_W{1'b0}}, fill_reg + 1'b1});
                                    position_reg <= spq_pkg::POS_W'(
                                        {{spq_pkg::POS_W{1'b0}}, ins_idx});
                                end
                            end
                            spq_pkg::KIND_REMOVE_MAX:
                            begin
                                if (fill_reg == '0)
                                begin
                                    status_reg <= spq_pkg::STATUS_EMPTY;
                                end
                                else
                                begin
                                    fill_reg      <= fill_dec;
                                    count_reg     <= spq_pkg::COUNT_W'(
                                        {{spq_pkg::COUNT_W{1'b0}}, fill_dec});
                                    position_reg  <= spq_pkg::POS_W'(
                                        {{spq_pkg::POS_W{1'b0}}, top_idx});
                                    out_value_reg <= top_value;
                                end
                            end
                            spq_pkg::KIND_REMOVE_VALUE, spq_pkg::KIND_SEARCH,
                            spq_pkg::KIND_CHANGE:
                            begin
                                if (!hit)
                                begin
                                    status_reg <= spq_pkg::STATUS_NOT_FOUND;
                                end
                                else
                                begin
                                    position_reg  <= spq_pkg::POS_W'(
                                        {{spq_pkg::POS_W{1'b0}}, match_idx});
                                    out_value_reg <= value_reg;
                                    if (kind_reg != spq_pkg::KIND_SEARCH)
                                    begin
                                        fill_reg  <= fill_dec;
                                        count_reg <= spq_pkg::COUNT_W'(
                                            {{spq_pkg::COUNT_W{1'b0}}, fill_dec});
                                    end
                                    if (kind_reg == spq_pkg::KIND_CHANGE)
                                    begin
                                        // match removed, now place the new value
                                        done_reg      <= 1'b0;
                                        ins_phase_reg <= 1'b1;
                                        sav_pos_reg   <= match_idx;
                                        state_reg     <= S_RECMP;
                                    end
                                end
                            end
                            default:
                            begin
                                status_reg <= spq_pkg::STATUS_OK;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign out_value = out_value_reg;
    assign count     = count_reg;

endmodule

/* rtl/spq_cell.sv */
module spq_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occ,
    input  logic signed [spq_pkg::DATA_W-1:0]   left_data,
    input  logic                                left_le,
    input  logic signed [spq_pkg::DATA_W-1:0]   right_data,
    output logic signed [spq_pkg::DATA_W-1:0]   data,
    output logic                                lt,
    output logic                                eq
);

    logic signed [spq_pkg::DATA_W-1:0] data_reg;
    logic signed [spq_pkg::DATA_W-1:0] data_next;
    logic                              lt_reg;
    logic                              eq_reg;
    logic                              le;

    assign le = lt_reg | eq_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            spq_pkg::CELL_INS:
            begin
                // cells above the insertion point move up by one
                if (!le)
                begin
                    data_next = left_le ? ctrl.key : left_data;
                end
            end
            spq_pkg::CELL_DEL:
            begin
                // cells from the first match upwards move down by one
                if (!lt_reg)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.op == spq_pkg::CELL_CMP)
        begin
            lt_reg <= occ && (data_reg < ctrl.key);
            eq_reg <= occ && (data_reg == ctrl.key);
        end
    end

    assign data = data_reg;
    assign lt   = lt_reg;
    assign eq   = eq_reg;

endmodule

/* bench/sorted_priority_queue_unit_test.sv */
module sorted_priority_queue_unit_test;

    // store size under test, kept at the block's default
    localparam int QUEUE_DEPTH = 16;

    // signed extremes of a stored value
    localparam logic signed [spq_pkg::DATA_W-1:0] VALUE_MIN =
        {1'b1, {(spq_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [spq_pkg::DATA_W-1:0] VALUE_MAX =
        {1'b0, {(spq_pkg::DATA_W-1){1'b1}}};

    // run limit, far beyond the slowest correct run
    localparam int RUN_LIMIT = 2000000;
    // settling after the last result
    localparam int SETTLE_CYCLES = 8;
    // bound on the wait for outstanding results at the end
    localparam int DRAIN_LIMIT = 2000;

    // one expected result, field by field
    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0]       status;
        logic [spq_pkg::POS_W-1:0]          position;
        logic signed [spq_pkg::DATA_W-1:0]  out_value;
        logic [spq_pkg::COUNT_W-1:0]        count;
    } queue_result_t;

    logic                                 clk;
    logic                                 rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [spq_pkg::KIND_W-1:0]           kind = '0;
    logic signed [spq_pkg::DATA_W-1:0]    value = '0;
    logic signed [spq_pkg::DATA_W-1:0]    new_value = '0;
    logic                                 done;
    logic [spq_pkg::STATUS_W-1:0]         status;
    logic [spq_pkg::POS_W-1:0]            position;
    logic signed [spq_pkg::DATA_W-1:0]    out_value;
    logic [spq_pkg::COUNT_W-1:0]          count;

    // mirror of the sorted store, ascending from index zero
    logic signed [spq_pkg::DATA_W-1:0]    sorted_store [QUEUE_DEPTH];
    int                                   fill_level = 0;

    // results owed by the block, oldest first
    queue_result_t                        pending_results [$];
    int                                   error_count = 0;
    // random gaps between items on the request side
    bit                                   idle_enable = 1'b1;

    sorted_priority_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .value(value),
        .new_value(new_value),
        .done(done),
        .status(status),
        .position(position),
        .out_value(out_value),
        .count(count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("sorted_priority_queue_unit_test: errors");
        $finish;
    end

    // places a value after every entry less than or equal to it, returns its slot
    function automatic int place_sorted(input logic signed [spq_pkg::DATA_W-1:0] v);
        int slot;
        slot = fill_level;
        while (slot > 0 && sorted_store[slot-1] > v)
        begin
            sorted_store[slot] = sorted_store[slot-1];
            slot--;
        end
        sorted_store[slot] = v;
        fill_level++;
        return slot;
    endfunction

    // works out the result of one request and moves the mirror on
    function automatic queue_result_t predict_result(
        input logic [spq_pkg::KIND_W-1:0]          k,
        input logic signed [spq_pkg::DATA_W-1:0]   v,
        input logic signed [spq_pkg::DATA_W-1:0]   nv
    );
        queue_result_t r;
        int idx;
        int j;
        r = '0;
        case (k)
            spq_pkg::KIND_INSERT:
            begin
                if (fill_level >= QUEUE_DEPTH)
                    r.status = spq_pkg::STATUS_FULL;
                else
                    r.position = spq_pkg::POS_W'(place_sorted(v));
            end
            spq_pkg::KIND_REMOVE_MAX:
            begin
                if (fill_level == 0)
                    r.status = spq_pkg::STATUS_EMPTY;
                else
                begin
                    r.position = spq_pkg::POS_W'(fill_level - 1);
                    r.out_value = sorted_store[fill_level-1];
                    fill_level--;
                end
            end
            spq_pkg::KIND_REMOVE_VALUE, spq_pkg::KIND_SEARCH, spq_pkg::KIND_CHANGE:
            begin
                // first match is the lowest index
                idx = -1;
                for (j = 0; j < fill_level; j++)
                    if (idx < 0 && sorted_store[j] == v)
                        idx = j;
                if (idx < 0)
                    r.status = spq_pkg::STATUS_NOT_FOUND;
                else
                begin
                    r.position = spq_pkg::POS_W'(idx);
                    r.out_value = v;
                    if (k != spq_pkg::KIND_SEARCH)
                    begin
                        for (j = idx; j + 1 < fill_level; j++)
                            sorted_store[j] = sorted_store[j+1];
                        fill_level--;
                    end
                    // a change puts the new value back in its sorted place
                    if (k == spq_pkg::KIND_CHANGE)
                        void'(place_sorted(nv));
                end
            end
            default:
            begin
                // spare kinds leave the store alone
            end
        endcase
        r.count = spq_pkg::COUNT_W'(fill_level);
        return r;
    endfunction

    // operand mix: stored values for hits, extremes, a narrow band for duplicates, random words
    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 && fill_level > 0)
            return sorted_store[$urandom_range(0, fill_level - 1)];
        else if (sel < 60)
        begin
            case ($urandom_range(0, 4))
                0: return VALUE_MIN;
                1: return VALUE_MAX;
                2: return '0;
                3: return '1;
                default: return spq_pkg::DATA_W'(1);
            endcase
        end
        else if (sel < 80)
            return spq_pkg::DATA_W'($signed($urandom_range(0, 15)) - 8);
        else
            return $urandom;
    endfunction

    // start low for a burst of cycles
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // presents one item and holds it until the edge that accepts it;
    // entered and left on a rising edge, start stays high on the way out
    task automatic send_request(
        input logic [spq_pkg::KIND_W-1:0]          k,
        input logic signed [spq_pkg::DATA_W-1:0]   v,
        input logic signed [spq_pkg::DATA_W-1:0]   nv
    );
        start <= 1'b1;
        kind <= k;
        value <= v;
        new_value <= nv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_result(k, v, nv));
        if (idle_enable && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 9));
    endtask

    // every request kind but insert on an empty store, plus one spare kind
    task automatic test_empty_store();
        send_request(spq_pkg::KIND_REMOVE_MAX, $urandom, $urandom);
        send_request(spq_pkg::KIND_REMOVE_VALUE, '0, $urandom);
        send_request(spq_pkg::KIND_SEARCH, VALUE_MIN, $urandom);
        send_request(spq_pkg::KIND_CHANGE, spq_pkg::DATA_W'(5), spq_pkg::DATA_W'(7));
        send_request(spq_pkg::KIND_W'(spq_pkg::KIND_CHANGE + 1), $urandom, $urandom);
    endtask

    // fill with extremes and duplicates, then knock on a full store
    task automatic test_full_store();
        send_request(spq_pkg::KIND_INSERT, VALUE_MAX, $urandom);
        send_request(spq_pkg::KIND_INSERT, VALUE_MIN, $urandom);
        send_request(spq_pkg::KIND_INSERT, '0, $urandom);
        send_request(spq_pkg::KIND_INSERT, '1, $urandom);
        send_request(spq_pkg::KIND_INSERT, VALUE_MAX, $urandom);
        send_request(spq_pkg::KIND_INSERT, VALUE_MIN, $urandom);
        repeat (QUEUE_DEPTH - 6)
            send_request(spq_pkg::KIND_INSERT, $urandom, $urandom);
        // insert refused once full
        send_request(spq_pkg::KIND_INSERT, '0, $urandom);
        // change still works when full: out first, then in
        send_request(spq_pkg::KIND_CHANGE, VALUE_MIN, VALUE_MAX);
        send_request(spq_pkg::KIND_SEARCH, VALUE_MAX, $urandom);
    endtask

    // removals and a change with no match
    task automatic test_removals();
        send_request(spq_pkg::KIND_REMOVE_VALUE, '1, $urandom);
        send_request(spq_pkg::KIND_REMOVE_MAX, $urandom, $urandom);
        send_request(spq_pkg::KIND_CHANGE, spq_pkg::DATA_W'(1), VALUE_MIN);
    endtask

    // random items with a given share of inserts
    task automatic random_items(input int n, input int insert_pct);
        logic [spq_pkg::KIND_W-1:0] k;
        logic signed [spq_pkg::DATA_W-1:0] nv;
        int sub;
        repeat (n)
        begin
            nv = $urandom;
            if ($urandom_range(0, 99) < insert_pct)
                k = spq_pkg::KIND_INSERT;
            else
            begin
                sub = $urandom_range(0, 20);
                if (sub == 0)
                    k = spq_pkg::KIND_W'(spq_pkg::KIND_CHANGE + $urandom_range(1, 3));
                else if (sub <= 5)
                    k = spq_pkg::KIND_REMOVE_MAX;
                else if (sub <= 10)
                    k = spq_pkg::KIND_REMOVE_VALUE;
                else if (sub <= 15)
                    k = spq_pkg::KIND_SEARCH;
                else
                begin
                    k = spq_pkg::KIND_CHANGE;
                    nv = pick_operand();
                end
            end
            send_request(k, pick_operand(), nv);
        end
    endtask

    // insert-heavy, keeps running into a full store
    task automatic test_random_fill();
        random_items(120, 70);
    endtask

    // removal-heavy, keeps running into an empty store
    task automatic test_random_drain();
        random_items(110, 10);
    endtask

    // balanced traffic around the middle of the store
    task automatic test_random_mixed();
        random_items(140, 45);
    endtask

    // balanced traffic with start held high throughout
    task automatic test_random_back_to_back();
        idle_enable = 1'b0;
        random_items(80, 45);
    endtask

    // result checker: each done strobe against the oldest expectation
    always @(posedge clk)
    begin
        queue_result_t expected;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d position %0d",
                       status, position);
                error_count++;
            end
            else
            begin
                expected = pending_results.pop_front();
                if (status !== expected.status)
                begin
                    $error("status: expected %0d, got %0d", expected.status, status);
                    error_count++;
                end
                if (position !== expected.position)
                begin
                    $error("position: expected %0d, got %0d", expected.position, position);
                    error_count++;
                end
                if (out_value !== expected.out_value)
                begin
                    $error("out_value: expected %0d, got %0d", expected.out_value, out_value);
                    error_count++;
                end
                if (count !== expected.count)
                begin
                    $error("count: expected %0d, got %0d", expected.count, count);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_full_store();
        test_removals();
        test_random_fill();
        test_random_drain();
        test_random_mixed();
        test_random_back_to_back();
        start <= 1'b0;

        // let outstanding results come home, then a few quiet cycles
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("sorted_priority_queue_unit_test: clean");
        else
            $display("sorted_priority_queue_unit_test: errors");
        $finish;
    end

endmodule
